// File: rtl/oscp_pkg.sv
package oscp_pkg;

	// serial word and memory defaults
	localparam int WORD_BITS     = 16;
	localparam int RAM_WORDS_DEF = 288;
	localparam int COUNT_BITS    = $clog2(WORD_BITS);

	// stream widths, padded to whole bytes
	localparam int IN_TDATA_BITS  = 16;
	localparam int OUT_TDATA_BITS = 88;
	localparam int OUT_FIELD_BITS = 82;

	// register map above display ram
	localparam logic [15:0] REG_BASE   = 16'h0120;
	localparam logic [15:0] REG_HSIZE  = 16'h0121;
	localparam logic [15:0] REG_VSIZE  = 16'h0122;
	localparam logic [15:0] REG_SCROLL = 16'h0123;
	localparam logic [15:0] REG_BLINK  = 16'h0125;
	localparam logic [15:0] REG_COLOR  = 16'h0126;
	localparam logic [15:0] REG_ERASE  = 16'h0127;
	localparam logic [15:0] ADDR_LAST  = 16'h0127;

	localparam logic [15:0] FILL_WORD  = 16'h007F;
	localparam logic [6:0]  BLINK_SLOW = 7'h40;
	localparam logic [6:0]  BLINK_FAST = 7'h20;

	typedef enum logic [1:0] {
		OP_DATA_PIN,
		OP_CLOCK_PIN,
		OP_RESET_PIN,
		OP_READ
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMIT,
		ST_FILL
	} state_t;

endpackage

// File: rtl/osd_serial_command_port.sv
// flow: a word is accepted, executed in the next cycle and registered for the master side
//   via idle, execute, emit; emit waits on back-pressure, and no new word is taken until idle
// an erase (bit 5 written to 0x127) adds a fill pass after emit: the fill walks one ram word a cycle
// reset: arst_n resets all control state and settings, then the same fill pass runs over
//   every ram word before the first word is accepted
module osd_serial_command_port #(
	parameter int RAM_WORDS = oscp_pkg::RAM_WORDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave side
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tdata: pin_level[0], read_address[9:1], zeros above
	input  logic [oscp_pkg::IN_TDATA_BITS-1:0]  s_tdata,
	// tuser: operation[1:0]
	input  logic [1:0]                          s_tuser,
	// master side
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tdata: word_done[0], word_address[16:1], word_data[32:17], read_data[48:33],
	//   horiz_sizes[54:49], vert_sizes[60:55], scroll_fraction[65:61], line_space[67:66],
	//   scroll_rows[71:68], blink_mask[78:72], raster_color[81:79], zeros above
	output logic [oscp_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	// tuser: word_kind[0]
	output logic [0:0]                          m_tuser
);

	localparam int AW = $clog2(RAM_WORDS);
	localparam int WB = oscp_pkg::WORD_BITS;
	localparam int CB = oscp_pkg::COUNT_BITS;
	localparam logic [AW-1:0] FILL_LAST  = AW'(RAM_WORDS - 1);
	localparam logic [CB-1:0] COUNT_LAST = CB'(WB - 1);

	// sequencer
	oscp_pkg::state_t state_q, state_d;
	logic exec, emit, fill_step;

	// captured input word
	oscp_pkg::op_t op_q;
	logic          lvl_q;
	logic [8:0]    raddr_q;

	// serial front end state
	logic          latched_q;
	logic          rst_asserted_q;
	logic [WB-1:0] shift_q;
	logic [CB-1:0] bit_count_q;
	logic          data_phase_q;
	logic [15:0]   write_address_q;

	// display settings
	logic [5:0] hsize_q;
	logic [5:0] vsize_q;
	logic [4:0] sfrac_q;
	logic [1:0] lspace_q;
	logic [3:0] srows_q;
	logic [6:0] blink_q;
	logic [2:0] color_q;

	// result of the executed word
	logic          res_done_q;
	logic          res_kind_q;
	logic [15:0]   res_waddr_q;
	logic [15:0]   res_wdata_q;
	logic          res_rd_hit_q;
	logic          erase_q;
	logic [AW-1:0] fill_idx_q;

	// output register
	logic                                m_valid_q;
	logic [oscp_pkg::OUT_TDATA_BITS-1:0] m_tdata_q;
	logic                                m_kind_q;

	// display ram
	logic [15:0]   mem [RAM_WORDS];
	logic [15:0]   rd_data_q;
	logic          mem_we;
	logic [AW-1:0] mem_widx;
	logic [15:0]   mem_wdata;
	logic          rd_en;
	logic [AW-1:0] rd_idx;

	// shared incrementer: fill index, bit count or write address
	logic [15:0] inc_a, inc_y, next_addr;

	logic          clk_edge, word_end, data_wr, reg_hit, erase_hit, rd_in_range;
	logic [WB-1:0] new_shift;
	logic [15:0]   rdata_out;

	// ---------------------------------------------------------------------
	// sequencer: one word is captured, executed, then emitted
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oscp_pkg::ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		exec      = 1'b0;
		emit      = 1'b0;
		fill_step = 1'b0;
		case (state_q)
			oscp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = oscp_pkg::ST_EXEC;
				end
			end
			oscp_pkg::ST_EXEC: begin
				exec    = 1'b1;
				state_d = oscp_pkg::ST_EMIT;
			end
			oscp_pkg::ST_EMIT: begin
				// output register free or being drained this cycle
				if (!m_valid_q || m_tready) begin
					emit    = 1'b1;
					state_d = erase_q ? oscp_pkg::ST_FILL : oscp_pkg::ST_IDLE;
				end
			end
			oscp_pkg::ST_FILL: begin
				fill_step = 1'b1;
				if (fill_idx_q == FILL_LAST) begin
					state_d = oscp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = oscp_pkg::ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// execute decode
	// ---------------------------------------------------------------------
	assign clk_edge  = exec && (op_q == oscp_pkg::OP_CLOCK_PIN) && lvl_q && !rst_asserted_q;
	assign word_end  = clk_edge && (bit_count_q == COUNT_LAST);
	assign new_shift = {latched_q, shift_q[WB-1:1]};   // lsb first, new bit enters at the top
	assign data_wr   = word_end && data_phase_q;
	// 0x120..0x127 are settings registers and shadow any ram there
	assign reg_hit   = (write_address_q[15:3] == oscp_pkg::REG_BASE[15:3]);
	assign erase_hit = data_wr && (write_address_q == oscp_pkg::REG_ERASE) && new_shift[5];

	assign inc_a = fill_step ? 16'(fill_idx_q) :
	               (word_end ? write_address_q : 16'(bit_count_q));
	assign inc_y = inc_a + 16'd1;
	// wrap to 0 past the last register address
	assign next_addr = (inc_y > oscp_pkg::ADDR_LAST) ? 16'd0 : inc_y;

	assign mem_we    = fill_step ||
	                   (data_wr && !reg_hit && (32'(write_address_q) < 32'(RAM_WORDS)));
	assign mem_widx  = fill_step ? fill_idx_q : AW'(write_address_q);
	assign mem_wdata = fill_step ? oscp_pkg::FILL_WORD : 16'(new_shift);

	assign rd_in_range = (32'(raddr_q) < 32'(RAM_WORDS));
	assign rd_en       = exec && (op_q == oscp_pkg::OP_READ);
	assign rd_idx      = AW'(raddr_q);

	// ---------------------------------------------------------------------
	// input capture
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q    <= oscp_pkg::op_t'(s_tuser);
			lvl_q   <= s_tdata[0];
			raddr_q <= s_tdata[9:1];
		end
	end

	// ---------------------------------------------------------------------
	// serial front end and settings
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q       <= 1'b0;
			rst_asserted_q  <= 1'b0;
			shift_q         <= '0;
			bit_count_q     <= '0;
			data_phase_q    <= 1'b0;
			write_address_q <= '0;
			hsize_q         <= '0;
			vsize_q         <= '0;
			sfrac_q         <= '0;
			lspace_q        <= '0;
			srows_q         <= '0;
			blink_q         <= oscp_pkg::BLINK_SLOW;
			color_q         <= '0;
		end else if (exec) begin
			case (op_q)
				oscp_pkg::OP_DATA_PIN: begin
					latched_q <= lvl_q;
				end
				oscp_pkg::OP_CLOCK_PIN: begin
					if (word_end) begin
						bit_count_q <= '0;
						shift_q     <= '0;
						if (!data_phase_q) begin
							write_address_q <= 16'(new_shift);
							data_phase_q    <= 1'b1;
						end else begin
							write_address_q <= next_addr;
							case (write_address_q)
								oscp_pkg::REG_HSIZE: begin
									hsize_q <= new_shift[11:6];
								end
								oscp_pkg::REG_VSIZE: begin
									vsize_q <= new_shift[11:6];
								end
								oscp_pkg::REG_SCROLL: begin
									sfrac_q  <= new_shift[4:0];
									lspace_q <= new_shift[6:5];
									srows_q  <= new_shift[11:8];
								end
								oscp_pkg::REG_BLINK: begin
									blink_q <= new_shift[2] ? oscp_pkg::BLINK_FAST
									                        : oscp_pkg::BLINK_SLOW;
								end
								oscp_pkg::REG_COLOR: begin
									color_q <= new_shift[2:0];
								end
								default: begin
								end
							endcase
						end
					end else if (clk_edge) begin
						bit_count_q <= inc_y[CB-1:0];
						shift_q     <= new_shift;
					end
				end
				oscp_pkg::OP_RESET_PIN: begin
					rst_asserted_q <= lvl_q;
					if (lvl_q) begin
						bit_count_q  <= '0;
						shift_q      <= '0;
						data_phase_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// result of the executed word
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (exec) begin
			res_done_q   <= word_end;
			res_kind_q   <= data_wr;
			res_waddr_q  <= word_end ? (data_phase_q ? write_address_q : 16'(new_shift)) : 16'd0;
			res_wdata_q  <= word_end ? 16'(new_shift) : 16'd0;
			res_rd_hit_q <= (op_q == oscp_pkg::OP_READ) && rd_in_range;
		end
	end

	// erase request and fill sweep, also run once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_q    <= 1'b0;
			fill_idx_q <= '0;
		end else begin
			if (exec) begin
				erase_q <= erase_hit;
			end else if (fill_step) begin
				erase_q <= 1'b0;
			end
			if (emit) begin
				fill_idx_q <= '0;
			end else if (fill_step) begin
				fill_idx_q <= inc_y[AW-1:0];
			end
		end
	end

	// ---------------------------------------------------------------------
	// display ram, one write and one registered read port
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_widx] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	// ---------------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------------
	assign rdata_out = res_rd_hit_q ? rd_data_q : 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= {
				(oscp_pkg::OUT_TDATA_BITS - oscp_pkg::OUT_FIELD_BITS)'(0),
				color_q, blink_q, srows_q, lspace_q, sfrac_q, vsize_q, hsize_q,
				rdata_out, res_wdata_q, res_waddr_q, res_done_q
			};
			m_kind_q  <= res_kind_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_kind_q;

endmodule

// File: bench/osd_port_checker.sv
module osd_port_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [oscp_pkg::IN_TDATA_BITS-1:0]  s_tdata,
	input  logic [1:0]                          s_tuser,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [oscp_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	input  logic [0:0]                          m_tuser,
	output int                                  errors,
	output int                                  outstanding
);

	import oscp_pkg::*;

	localparam logic [15:0] REG_SPARE = 16'h0124;
	localparam int          NUM_RAM   = RAM_WORDS_DEF;

	typedef struct packed {
		logic        done;
		logic        kind;
		logic [15:0] addr;
		logic [15:0] data;
		logic [15:0] rdata;
		logic [5:0]  hsize;
		logic [5:0]  vsize;
		logic [4:0]  fraction;
		logic [1:0]  spacing;
		logic [3:0]  rows;
		logic [6:0]  blink;
		logic [2:0]  color;
	} osd_status_t;

	// shadow copy of the port state
	logic        pin_data;
	logic        pin_reset;
	logic [15:0] shreg;
	logic [4:0]  nbits;
	logic        in_data;
	logic [15:0] waddr;
	logic [15:0] display_ram [NUM_RAM];
	logic [11:0] sizes;
	logic [10:0] scroll;
	logic [6:0]  blink;
	logic [2:0]  color;

	osd_status_t status_q [$];

	initial begin
		errors = 0;
		outstanding = 0;
	end

	function automatic void fill_display();
		for (int i = 0; i < NUM_RAM; i++)
			display_ram[i] = FILL_WORD;
	endfunction

	function automatic void reset_shadow();
		pin_data = 1'b0;
		pin_reset = 1'b0;
		shreg = '0;
		nbits = '0;
		in_data = 1'b0;
		waddr = '0;
		fill_display();
		sizes = '0;
		scroll = '0;
		blink = BLINK_SLOW;
		color = '0;
	endfunction

	// registers above the display ram win over the ram words there
	function automatic void store_word(logic [15:0] a, logic [15:0] d);
		case (a)
			REG_HSIZE: sizes[5:0] = d[11:6];
			REG_VSIZE: sizes[11:6] = d[11:6];
			REG_SCROLL: scroll = {d[11:8], d[6:5], d[4:0]};
			REG_BLINK: blink = d[2] ? BLINK_FAST : BLINK_SLOW;
			REG_COLOR: color = d[2:0];
			REG_ERASE: if (d[5]) fill_display();
			REG_BASE, REG_SPARE: ;
			default: if (a < NUM_RAM) display_ram[a] = d;
		endcase
	endfunction

	function automatic osd_status_t step_port(op_t op, logic lvl, logic [8:0] ra);
		osd_status_t r;
		r = '0;
		case (op)
			OP_DATA_PIN: pin_data = lvl;
			OP_CLOCK_PIN: if (!pin_reset && lvl) begin
				shreg = {pin_data, shreg[15:1]};
				nbits = nbits + 5'd1;
				if (nbits >= WORD_BITS) begin
					r.done = 1'b1;
					r.data = shreg;
					if (!in_data) begin
						waddr = shreg;
						in_data = 1'b1;
						r.addr = waddr;
					end else begin
						r.kind = 1'b1;
						r.addr = waddr;
						store_word(waddr, shreg);
						waddr = waddr + 16'd1;
						if (waddr > ADDR_LAST)
							waddr = '0;
					end
					nbits = '0;
					shreg = '0;
				end
			end
			OP_RESET_PIN: begin
				pin_reset = lvl;
				if (lvl) begin
					nbits = '0;
					shreg = '0;
					in_data = 1'b0;
				end
			end
			default: if (ra < NUM_RAM) r.rdata = display_ram[ra];
		endcase
		r.hsize = sizes[5:0];
		r.vsize = sizes[11:6];
		r.fraction = scroll[4:0];
		r.spacing = scroll[6:5];
		r.rows = scroll[10:7];
		r.blink = blink;
		r.color = color;
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	task automatic compare_status(osd_status_t want, logic [OUT_TDATA_BITS-1:0] td, logic kind);
		check_field("word_done", want.done, td[0]);
		check_field("word_kind", want.kind, kind);
		check_field("word_address", want.addr, td[16:1]);
		check_field("word_data", want.data, td[32:17]);
		check_field("read_data", want.rdata, td[48:33]);
		check_field("horiz_sizes", want.hsize, td[54:49]);
		check_field("vert_sizes", want.vsize, td[60:55]);
		check_field("scroll_fraction", want.fraction, td[65:61]);
		check_field("line_space", want.spacing, td[67:66]);
		check_field("scroll_rows", want.rows, td[71:68]);
		check_field("blink_mask", want.blink, td[78:72]);
		check_field("raster_color", want.color, td[81:79]);
		check_field("tdata padding", '0, td[87:82]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_shadow();
			status_q.delete();
			outstanding = 0;
		end else begin
			// a result never leaves in the same cycle its word came in, so pop first
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					errors++;
					$display("%0t unexpected word: expected none, actual tdata %0h kind %0h",
						$time, m_tdata, m_tuser);
				end else begin
					compare_status(status_q.pop_front(), m_tdata, m_tuser[0]);
				end
			end
			if (s_tvalid && s_tready)
				status_q.push_back(step_port(op_t'(s_tuser), s_tdata[0], s_tdata[9:1]));
			outstanding = status_q.size();
		end
	end

endmodule

// File: bench/tb_osd_serial_command_port.sv
module tb_osd_serial_command_port;

	import oscp_pkg::*;

	localparam int STIM_ITEMS = 1800;
	localparam int LAST_READ  = 295;

	logic                      clk      = 1'b0;
	logic                      arst_n   = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [IN_TDATA_BITS-1:0]  s_tdata  = '0;
	logic [1:0]                s_tuser  = OP_DATA_PIN;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic [0:0]                m_tuser;

	int   errors;
	int   outstanding;
	int   words_sent = 0;
	logic data_level = 1'b0;
	logic no_idle    = 1'b0;

	osd_serial_command_port u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	osd_port_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure, off during the steady stretch
	always @(posedge clk)
		m_tready <= no_idle || ($urandom_range(99) >= 20);

	function automatic logic [8:0] any_read_addr();
		return 9'($urandom_range(LAST_READ));
	endfunction

	// one pin event word, held until taken
	task automatic send_word(input op_t op, input logic lvl, input logic [8:0] ra);
		if (!no_idle && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, ra, lvl};
		do @(posedge clk); while (!s_tready);
		if (op == OP_DATA_PIN)
			data_level = lvl;
		words_sent++;
		no_idle = (words_sent >= 600) && (words_sent < 900);
	endtask

	// clock out the low bits of a serial frame, lsb first, with stray events mixed in
	task automatic shift_frame(input logic [15:0] frame, input int nbits);
		for (int i = 0; i < nbits; i++) begin
			if (frame[i] != data_level || $urandom_range(3) == 0)
				send_word(OP_DATA_PIN, frame[i], any_read_addr());
			if ($urandom_range(11) == 0)
				send_word(OP_CLOCK_PIN, 1'b0, any_read_addr());
			if ($urandom_range(11) == 0)
				send_word(OP_READ, 1'($urandom_range(1)), any_read_addr());
			send_word(OP_CLOCK_PIN, 1'b1, any_read_addr());
		end
	endtask

	// reset pin pulse, address frame, then a run of data frames and a few read-backs
	task automatic write_burst();
		logic [15:0] base;
		int          count;
		int          ra;
		case ($urandom_range(9))
			0, 1, 2, 3: base = 16'($urandom_range(16'h0127, 16'h0110));
			4, 5, 6, 7: base = 16'($urandom_range(16'h0127));
			8: base = 16'($urandom_range(16'hFFFF, 16'h0128));
			default: base = 16'($urandom);
		endcase
		count = $urandom_range(6, 1);
		send_word(OP_RESET_PIN, 1'b1, any_read_addr());
		if ($urandom_range(9) == 0)
			send_word(OP_CLOCK_PIN, 1'b1, any_read_addr());
		send_word(OP_RESET_PIN, 1'b0, any_read_addr());
		shift_frame(base, 16);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) == 0) begin
				// cut a frame short, then start over at the same address
				shift_frame(16'($urandom), $urandom_range(15, 1));
				send_word(OP_RESET_PIN, 1'b1, any_read_addr());
				send_word(OP_RESET_PIN, 1'b0, any_read_addr());
				shift_frame(base, 16);
			end
			shift_frame(16'($urandom), 16);
		end
		repeat ($urandom_range(3, 1)) begin
			ra = int'(base) + $urandom_range(count);
			if (ra > LAST_READ)
				ra = $urandom_range(LAST_READ);
			send_word(OP_READ, 1'($urandom_range(1)), 9'(ra));
		end
	endtask

	initial begin
		int pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// ram edges right after the power-up fill
		send_word(OP_READ, 1'b0, 9'd0);
		send_word(OP_READ, 1'b1, 9'd287);
		send_word(OP_READ, 1'b0, 9'd288);
		send_word(OP_READ, 1'b1, 9'd295);
		// clock low is ignored, clock high shifts
		send_word(OP_CLOCK_PIN, 1'b0, 9'd0);
		send_word(OP_CLOCK_PIN, 1'b1, 9'd295);
		send_word(OP_DATA_PIN, 1'b1, 9'd0);
		send_word(OP_CLOCK_PIN, 1'b1, 9'd0);
		send_word(OP_CLOCK_PIN, 1'b1, 9'd295);
		// clocks are dropped while the reset pin is held
		send_word(OP_RESET_PIN, 1'b1, 9'd0);
		send_word(OP_CLOCK_PIN, 1'b1, 9'd0);
		send_word(OP_RESET_PIN, 1'b1, 9'd295);
		send_word(OP_RESET_PIN, 1'b0, 9'd0);
		send_word(OP_CLOCK_PIN, 1'b1, 9'd0);
		send_word(OP_DATA_PIN, 1'b0, 9'd295);
		send_word(OP_CLOCK_PIN, 1'b1, 9'd0);

		while (words_sent < STIM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				write_burst();
			end else if (pick < 88) begin
				repeat ($urandom_range(8, 1))
					send_word(op_t'($urandom_range(3)), 1'($urandom_range(1)), any_read_addr());
			end else begin
				repeat ($urandom_range(4, 1))
					send_word(OP_READ, 1'($urandom_range(1)), any_read_addr());
			end
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		wait (outstanding == 0);
		// leave room for a trailing erase pass
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("osd_serial_command_port verification clean");
		else
			$display("osd_serial_command_port verification failed");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("osd_serial_command_port verification failed");
		$finish;
	end

endmodule
